### hw/rtl/wpf_pkg.sv
`timescale 1ns / 1ps

package wpf_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int PTR_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = PTR_W + 1;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int STEP_W       = $clog2(CORDIC_N);
    localparam int CORDIC_W     = 45;
    localparam int CORDIC_IN_W  = 34;

    localparam int SPIN_MOVE_MIN     = 655;
    localparam int STRAIGHT_TURN_MIN = 1310;

    typedef enum logic [2:0] {
        REG_ANG_STEP     = 3'd0,
        REG_LIN_STEP     = 3'd1,
        REG_V_TARGET     = 3'd2,
        REG_SPIN_LIMIT   = 3'd3,
        REG_ARRIVE       = 3'd4,
        REG_WIDE_ANGLE   = 3'd5,
        REG_NARROW_ANGLE = 3'd6
    } t_reg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_CMD  = 2'd1,
        STATUS_DONE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        MUL_QXQY = 4'd0,
        MUL_QWQZ = 4'd1,
        MUL_QWQW = 4'd2,
        MUL_QXQX = 4'd3,
        MUL_QYQY = 4'd4,
        MUL_QZQZ = 4'd5,
        MUL_QXQZ = 4'd6,
        MUL_QWQY = 4'd7,
        MUL_LVTV = 4'd8,
        MUL_DXDX = 4'd9,
        MUL_DYDY = 4'd10,
        MUL_RR   = 4'd11
    } t_mul_op;

    // Arctangent of 2^-i, with a full turn equal to 2^32.
    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/wpf_path_mem.sv
`timescale 1ns / 1ps

module wpf_path_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [wpf_pkg::PTR_W-1:0] i_waddr,
    input  logic signed [31:0]        i_wx,
    input  logic signed [31:0]        i_wy,
    input  logic [wpf_pkg::PTR_W-1:0] i_raddr,
    output logic signed [31:0]        o_rx,
    output logic signed [31:0]        o_ry
);

    logic signed [31:0] r_mem_x [wpf_pkg::MAX_POINTS];
    logic signed [31:0] r_mem_y [wpf_pkg::MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
        o_rx <= r_mem_x[i_raddr];
        o_ry <= r_mem_y[i_raddr];
    end

endmodule

### hw/rtl/wpf_mul.sv
`timescale 1ns / 1ps

module wpf_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  wpf_pkg::t_mul_op     i_tag,
    input  logic signed [32:0]   i_a,
    input  logic signed [32:0]   i_b,
    output logic                 o_valid,
    output wpf_pkg::t_mul_op     o_tag,
    output logic signed [65:0]   o_p
);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_en;
        end
        o_tag <= i_tag;
        o_p   <= i_a * i_b;
    end

endmodule

### hw/rtl/wpf_cordic.sv
`timescale 1ns / 1ps

module wpf_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [wpf_pkg::CORDIC_IN_W-1:0] i_x,
    input  logic signed [wpf_pkg::CORDIC_IN_W-1:0] i_y,
    output logic                                  o_done,
    output logic [15:0]                           o_angle
);

    localparam int W = wpf_pkg::CORDIC_W;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    t_cstate                        r_state;
    logic signed [W-1:0]            r_x, r_y;
    logic [31:0]                    r_z;
    logic [wpf_pkg::STEP_W-1:0]     r_i;

    logic signed [W-1:0] w_ex, w_ey, w_ax, w_ay, w_m, w_xs, w_ys;
    logic [31:0]         w_atan, w_z;

    assign w_ex   = W'(i_x);
    assign w_ey   = W'(i_y);
    assign w_ax   = (r_x < 0) ? -r_x : r_x;
    assign w_ay   = (r_y < 0) ? -r_y : r_y;
    assign w_m    = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = wpf_pkg::atan_val(5'(r_i));
    assign w_z    = (r_y >= 0) ? r_z + w_atan : r_z - w_atan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (w_ex == 0 && w_ey == 0) begin
                            o_done  <= 1'b1;
                            o_angle <= 16'd0;
                        end else begin
                            if (w_ex < 0) begin
                                if (w_ey >= 0) begin
                                    r_x <= w_ey;
                                    r_y <= -w_ex;
                                    r_z <= 32'h40000000;
                                end else begin
                                    r_x <= -w_ey;
                                    r_y <= w_ex;
                                    r_z <= 32'hC0000000;
                                end
                            end else begin
                                r_x <= w_ex;
                                r_y <= w_ey;
                                r_z <= 32'h0;
                            end
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    // Eight doublings at once stay below the target while the
                    // larger magnitude is under 2^32.
                    if (w_m >= (W'(1) <<< 40)) begin
                        r_i     <= '0;
                        r_state <= C_ITER;
                    end else if (w_m < (W'(1) <<< 32)) begin
                        r_x <= r_x <<< 8;
                        r_y <= r_y <<< 8;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
                C_ITER: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                    end
                    r_z <= w_z;
                    if (r_i == wpf_pkg::STEP_W'(wpf_pkg::CORDIC_N - 1)) begin
                        o_done  <= 1'b1;
                        o_angle <= 16'((w_z + 32'h8000) >> 16);
                        r_state <= C_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/waypoint_heading_follower.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready   waypoint load or control tick
// m_axis    out        m_axis_tvalid / m_axis_tready   command for one tick
// apb       in         psel, penable, pwrite, pready   seven step/limit registers
// A tick that issues a command runs twelve products through the shared multiplier,
// then two CORDIC runs (normalizing shifts plus 16 rotations each) on one shared
// rotator; a singular yaw skips the first run. Ticks with no path or a finished
// path go straight to the output stage.
// Reset is synchronous and clears control state; waypoint memory is not cleared.
// The input is not ready while a tick is in work or its result waits to leave.

module waypoint_heading_follower (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // robot_x, robot_y, quat_x, quat_y, quat_z, quat_w, lin_vel, turn_vel,
    // point_x, point_y
    input  logic [255:0] s_axis_tdata,
    // kind
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lin_cmd, turn_cmd, target_index, advanced, zero pad
    output logic [79:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PW = wpf_pkg::PTR_W;
    localparam int CW = wpf_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL, S_WAIT, S_YAW, S_YAWW, S_BRG, S_BRGW, S_ANG, S_DEC, S_OUT
    } t_state;

    t_state r_state;

    logic [16:0] r_ang_step, r_lin_step;
    logic [18:0] r_v_target;
    logic [19:0] r_spin_limit, r_arrive;
    logic [14:0] r_wide, r_narrow;

    logic [PW-1:0] r_lp, r_follow;
    logic [CW-1:0] r_count;
    logic          r_finished;

    logic signed [31:0] r_rx, r_ry, r_lv, r_tv;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [32:0] r_dx, r_dy;
    wpf_pkg::t_mul_op   r_k;

    logic signed [35:0] r_an, r_ayd, r_ad, r_ag;
    logic signed [63:0] r_lt;
    logic [41:0]        r_ds;
    logic [39:0]        r_rr;

    logic [15:0]        r_yaw, r_brg, r_mag;
    logic signed [1:0]  r_esg;

    wpf_pkg::t_status   r_res_status;
    logic signed [31:0] r_res_lin, r_res_turn;
    logic [PW-1:0]      r_res_idx;
    logic               r_res_adv;

    logic               r_m_valid;
    wpf_pkg::t_status   r_m_status;
    logic signed [31:0] r_m_lin, r_m_turn;
    logic [PW-1:0]      r_m_idx;
    logic               r_m_adv;

    logic w_s_acc, w_load, w_cfg_wr;
    assign w_s_acc  = s_axis_tvalid && s_axis_tready;
    assign w_load   = w_s_acc && (wpf_pkg::t_kind'(s_axis_tuser[0]) == wpf_pkg::KIND_LOAD);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign pready        = 1'b1;

    // Path memory
    logic signed [31:0] w_mem_x, w_mem_y;
    wpf_path_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_lp),
        .i_wx    (s_axis_tdata[223:192]),
        .i_wy    (s_axis_tdata[255:224]),
        .i_raddr (r_follow),
        .o_rx    (w_mem_x),
        .o_ry    (w_mem_y)
    );

    // Shared multiplier
    logic signed [32:0] w_ma, w_mb, w_qx, w_qy, w_qz, w_qw, w_lv, w_tv, w_rad;
    logic               w_pvalid;
    wpf_pkg::t_mul_op   w_ptag;
    logic signed [65:0] w_p;

    assign w_qx  = 33'(r_qx);
    assign w_qy  = 33'(r_qy);
    assign w_qz  = 33'(r_qz);
    assign w_qw  = 33'(r_qw);
    assign w_lv  = 33'(r_lv);
    assign w_tv  = 33'(r_tv);
    assign w_rad = {13'd0, r_arrive};

    always_comb begin
        case (r_k)
            wpf_pkg::MUL_QXQY: begin w_ma = w_qx;  w_mb = w_qy;  end
            wpf_pkg::MUL_QWQZ: begin w_ma = w_qw;  w_mb = w_qz;  end
            wpf_pkg::MUL_QWQW: begin w_ma = w_qw;  w_mb = w_qw;  end
            wpf_pkg::MUL_QXQX: begin w_ma = w_qx;  w_mb = w_qx;  end
            wpf_pkg::MUL_QYQY: begin w_ma = w_qy;  w_mb = w_qy;  end
            wpf_pkg::MUL_QZQZ: begin w_ma = w_qz;  w_mb = w_qz;  end
            wpf_pkg::MUL_QXQZ: begin w_ma = w_qx;  w_mb = w_qz;  end
            wpf_pkg::MUL_QWQY: begin w_ma = w_qw;  w_mb = w_qy;  end
            wpf_pkg::MUL_LVTV: begin w_ma = w_lv;  w_mb = w_tv;  end
            wpf_pkg::MUL_DXDX: begin w_ma = r_dx;  w_mb = r_dx;  end
            wpf_pkg::MUL_DYDY: begin w_ma = r_dy;  w_mb = r_dy;  end
            default:           begin w_ma = w_rad; w_mb = w_rad; end
        endcase
    end

    wpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_state == S_MUL),
        .i_tag   (r_k),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_valid (w_pvalid),
        .o_tag   (w_ptag),
        .o_p     (w_p)
    );

    // Shared CORDIC rotator
    logic signed [35:0] w_g2, w_ag2, w_n2;
    logic               w_sing, w_cstart, w_cdone;
    logic signed [wpf_pkg::CORDIC_IN_W-1:0] w_cx, w_cy;
    logic [15:0]        w_cang;

    assign w_g2   = r_ag <<< 1;
    assign w_ag2  = (w_g2 < 0) ? -w_g2 : w_g2;
    assign w_n2   = r_an <<< 1;
    assign w_sing = (w_ag2 >= r_ad);
    assign w_cstart = (r_state == S_YAW && !w_sing) || (r_state == S_BRG);
    assign w_cx = (r_state == S_BRG) ? wpf_pkg::CORDIC_IN_W'(r_dx)
                                     : r_ayd[wpf_pkg::CORDIC_IN_W-1:0];
    assign w_cy = (r_state == S_BRG) ? wpf_pkg::CORDIC_IN_W'(r_dy)
                                     : w_n2[wpf_pkg::CORDIC_IN_W-1:0];

    wpf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .o_done  (w_cdone),
        .o_angle (w_cang)
    );

    // Heading error
    logic [15:0] w_diff;
    assign w_diff = r_brg - r_yaw;

    // Command decision
    logic signed [34:0] w_tv35, w_lv35, w_ang35, w_lin35, w_atv, w_alv, w_rt, w_art;
    logic signed [34:0] w_turn;
    logic signed [48:0] w_lin;
    logic signed [32:0] w_adx, w_ady;
    logic               w_near;

    assign w_tv35  = 35'(r_tv);
    assign w_lv35  = 35'(r_lv);
    assign w_ang35 = {18'd0, r_ang_step};
    assign w_lin35 = {18'd0, r_lin_step};
    assign w_atv   = (w_tv35 < 0) ? -w_tv35 : w_tv35;
    assign w_alv   = (w_lv35 < 0) ? -w_lv35 : w_lv35;

    always_comb begin
        if (w_atv < {15'd0, r_spin_limit}) begin
            if (r_esg > 0)      w_rt = w_tv35 + w_ang35;
            else if (r_esg < 0) w_rt = w_tv35 - w_ang35;
            else                w_rt = w_tv35;
        end else begin
            if (w_tv35 > 0)      w_rt = w_tv35 - w_ang35;
            else if (w_tv35 < 0) w_rt = w_tv35 + w_ang35;
            else                 w_rt = w_tv35;
        end
    end
    assign w_art = (w_rt < 0) ? -w_rt : w_rt;

    always_comb begin
        if (r_mag >= {1'b0, r_wide}) begin
            w_turn = w_rt;
            w_lin  = (w_art > 35'(wpf_pkg::SPIN_MOVE_MIN)) ? 49'(w_lv35 - w_lin35) : '0;
        end else if (r_mag <= {1'b0, r_narrow}) begin
            if (w_atv > 35'(wpf_pkg::STRAIGHT_TURN_MIN))
                w_turn = (w_tv35 > 0) ? w_tv35 - w_ang35 : w_tv35 + w_ang35;
            else
                w_turn = '0;
            if (w_alv < {16'd0, r_v_target})
                w_lin = 49'(w_lv35 + w_lin35);
            else if (w_lv35 > 0)
                w_lin = 49'(w_lv35 - w_lin35);
            else if (w_lv35 < 0)
                w_lin = 49'(w_lv35 + w_lin35);
            else
                w_lin = 49'(w_lv35);
        end else begin
            w_turn = w_rt;
            w_lin  = 49'(r_lt >>> 16);
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] s;
        if (v > 49'sd2147483647)       s = 32'sh7FFFFFFF;
        else if (v < -49'sd2147483648) s = 32'sh80000000;
        else                           s = v[31:0];
        return s;
    endfunction

    assign w_adx  = (r_dx < 0) ? -r_dx : r_dx;
    assign w_ady  = (r_dy < 0) ? -r_dy : r_dy;
    assign w_near = (w_adx < (33'sd1 <<< 20)) && (w_ady < (33'sd1 <<< 20)) &&
                    (r_ds < {2'd0, r_rr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ang_step   <= 17'd655;
            r_lin_step   <= 17'd655;
            r_v_target   <= 19'd32768;
            r_spin_limit <= 20'd131072;
            r_arrive     <= 20'd6554;
            r_wide       <= 15'd1820;
            r_narrow     <= 15'd273;
            r_lp         <= '0;
            r_count      <= '0;
            r_follow     <= '0;
            r_finished   <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (wpf_pkg::t_reg_idx'(paddr[4:2]))
                    wpf_pkg::REG_ANG_STEP:     r_ang_step   <= pwdata[16:0];
                    wpf_pkg::REG_LIN_STEP:     r_lin_step   <= pwdata[16:0];
                    wpf_pkg::REG_V_TARGET:     r_v_target   <= pwdata[18:0];
                    wpf_pkg::REG_SPIN_LIMIT:   r_spin_limit <= pwdata[19:0];
                    wpf_pkg::REG_ARRIVE:       r_arrive     <= pwdata[19:0];
                    wpf_pkg::REG_WIDE_ANGLE:   r_wide       <= pwdata[14:0];
                    wpf_pkg::REG_NARROW_ANGLE: r_narrow     <= pwdata[14:0];
                    default: ;
                endcase
            end

            // In S_OUT the output register is refilled instead of emptied.
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) r_m_valid <= 1'b0;

            if (w_pvalid) begin
                case (w_ptag)
                    wpf_pkg::MUL_QXQY: r_an <= w_p[35:0];
                    wpf_pkg::MUL_QWQZ: r_an <= r_an + w_p[35:0];
                    wpf_pkg::MUL_QWQW: begin r_ayd <= w_p[35:0]; r_ad <= w_p[35:0]; end
                    wpf_pkg::MUL_QXQX: begin r_ayd <= r_ayd + w_p[35:0]; r_ad <= r_ad + w_p[35:0]; end
                    wpf_pkg::MUL_QYQY: begin r_ayd <= r_ayd - w_p[35:0]; r_ad <= r_ad + w_p[35:0]; end
                    wpf_pkg::MUL_QZQZ: begin r_ayd <= r_ayd - w_p[35:0]; r_ad <= r_ad + w_p[35:0]; end
                    wpf_pkg::MUL_QXQZ: r_ag <= w_p[35:0];
                    wpf_pkg::MUL_QWQY: r_ag <= r_ag - w_p[35:0];
                    wpf_pkg::MUL_LVTV: r_lt <= w_p[63:0];
                    wpf_pkg::MUL_DXDX: r_ds <= w_p[41:0];
                    wpf_pkg::MUL_DYDY: r_ds <= r_ds + w_p[41:0];
                    default:           r_rr <= w_p[39:0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        if (r_lp == '0) begin
                            r_follow   <= '0;
                            r_finished <= 1'b0;
                        end
                        if (s_axis_tlast) begin
                            r_count <= {1'b0, r_lp} + 1'b1;
                            r_lp    <= '0;
                        end else begin
                            if (r_lp == '0) r_count <= '0;
                            if (r_lp != PW'(wpf_pkg::MAX_POINTS - 1)) r_lp <= r_lp + 1'b1;
                        end
                    end else if (w_s_acc) begin
                        r_rx <= s_axis_tdata[31:0];
                        r_ry <= s_axis_tdata[63:32];
                        r_qx <= s_axis_tdata[79:64];
                        r_qy <= s_axis_tdata[95:80];
                        r_qz <= s_axis_tdata[111:96];
                        r_qw <= s_axis_tdata[127:112];
                        r_lv <= s_axis_tdata[159:128];
                        r_tv <= s_axis_tdata[191:160];
                        r_res_lin  <= '0;
                        r_res_turn <= '0;
                        r_res_adv  <= 1'b0;
                        r_res_idx  <= r_follow;
                        if (r_count == '0) begin
                            r_res_status <= wpf_pkg::STATUS_NONE;
                            r_state      <= S_OUT;
                        end else if (r_finished || ({1'b0, r_follow} + 1'b1 >= r_count)) begin
                            r_finished   <= 1'b1;
                            r_res_status <= wpf_pkg::STATUS_DONE;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_dx    <= 33'(w_mem_x) - 33'(r_rx);
                    r_dy    <= 33'(w_mem_y) - 33'(r_ry);
                    r_k     <= wpf_pkg::MUL_QXQY;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_k == wpf_pkg::MUL_RR) r_state <= S_WAIT;
                    else r_k <= wpf_pkg::t_mul_op'(r_k + 4'd1);
                end
                S_WAIT: r_state <= S_YAW;
                S_YAW: begin
                    if (w_sing) begin
                        r_yaw   <= 16'd0;
                        r_state <= S_BRG;
                    end else begin
                        r_state <= S_YAWW;
                    end
                end
                S_YAWW: begin
                    if (w_cdone) begin
                        r_yaw   <= w_cang;
                        r_state <= S_BRG;
                    end
                end
                S_BRG: r_state <= S_BRGW;
                S_BRGW: begin
                    if (w_cdone) begin
                        r_brg   <= w_cang;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    // A half-turn error counts as negative.
                    r_mag   <= w_diff[15] ? 16'(-w_diff) : w_diff;
                    r_esg   <= (w_diff == 16'd0) ? 2'sd0 : (w_diff[15] ? -2'sd1 : 2'sd1);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_res_status <= wpf_pkg::STATUS_CMD;
                    r_res_lin    <= sat32(w_lin);
                    r_res_turn   <= sat32(49'(w_turn));
                    r_res_adv    <= w_near;
                    r_res_idx    <= w_near ? r_follow + 1'b1 : r_follow;
                    if (w_near) r_follow <= r_follow + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_lin    <= r_res_lin;
                        r_m_turn   <= r_res_turn;
                        r_m_idx    <= r_res_idx;
                        r_m_adv    <= r_res_adv;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (wpf_pkg::t_reg_idx'(paddr[4:2]))
            wpf_pkg::REG_ANG_STEP:     prdata = {15'd0, r_ang_step};
            wpf_pkg::REG_LIN_STEP:     prdata = {15'd0, r_lin_step};
            wpf_pkg::REG_V_TARGET:     prdata = {13'd0, r_v_target};
            wpf_pkg::REG_SPIN_LIMIT:   prdata = {12'd0, r_spin_limit};
            wpf_pkg::REG_ARRIVE:       prdata = {12'd0, r_arrive};
            wpf_pkg::REG_WIDE_ANGLE:   prdata = {17'd0, r_wide};
            wpf_pkg::REG_NARROW_ANGLE: prdata = {17'd0, r_narrow};
            default:                   prdata = 32'd0;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {5'd0, r_m_adv, 10'(r_m_idx), r_m_turn, r_m_lin};

endmodule

### dv/tb_waypoint_heading_follower.sv
`timescale 1ns / 1ps

module tb_waypoint_heading_follower;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 200;

    typedef struct {
        wpf_pkg::t_kind      kind;
        logic signed [31:0]  rx, ry;
        logic signed [15:0]  qx, qy, qz, qw;
        logic signed [31:0]  lv, tv, px, py;
        logic                last;
    } t_path_item;

    typedef struct {
        wpf_pkg::t_status           status;
        logic signed [31:0]         lin;
        logic signed [31:0]         turn;
        logic [wpf_pkg::PTR_W-1:0]  idx;
        logic                       adv;
    } t_steer_cmd;

    typedef struct {
        t_path_item  it;
        logic        typed;
        t_steer_cmd  res;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // robot_x, robot_y, quat_x, quat_y, quat_z, quat_w, lin_vel, turn_vel,
    // point_x, point_y
    logic [255:0] s_axis_tdata = '0;
    // kind
    logic [0:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // lin_cmd, turn_cmd, target_index, advanced, zero pad
    logic [79:0]  m_axis_tdata;
    // status
    logic [1:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    waypoint_heading_follower DUT (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's registers and path state.
    logic [16:0] ang_step, lin_step;
    logic [18:0] v_target;
    logic [19:0] spin_limit, arrive_r;
    logic [14:0] wide_ang, narrow_ang;
    logic [31:0] wp_x [wpf_pkg::MAX_POINTS];
    logic [31:0] wp_y [wpf_pkg::MAX_POINTS];
    int          load_ptr, pt_count, fol_idx;
    logic        path_done;

    t_steer_cmd  cmd_queue[$];
    int          errors = 0;
    int          cycles = 0;
    int          in_stall = 0;
    bit          idle_on = 1'b1;

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sgn_l(longint v);
        return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    function automatic longint sat_32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Vector angle in 16-bit binary angle units.
    function automatic logic [15:0] vec_angle(longint x, longint y);
        logic [31:0] z;
        longint      m, t, xs, ys;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 32'h40000000;
            end else begin
                t = x; x = -y; y = t; z = 32'hC0000000;
            end
        end
        m = abs_l(x) > abs_l(y) ? abs_l(x) : abs_l(y);
        while (m < (64'sd1 <<< 40)) begin
            m = m * 2; x = x * 2; y = y * 2;
        end
        for (int i = 0; i < wpf_pkg::CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + wpf_pkg::atan_val(i[4:0]);
            end else begin
                x = x - ys; y = y + xs; z = z - wpf_pkg::atan_val(i[4:0]);
            end
        end
        return 16'((z + 32'h8000) >> 16);
    endfunction

    function automatic longint steer_rate(longint tv, longint esg);
        if (abs_l(tv) < longint'(spin_limit))
            return tv + longint'(ang_step) * esg;
        return tv - sgn_l(tv) * longint'(ang_step);
    endfunction

    // Updates the shadow state; returns 1 with a command for ticks.
    function automatic bit steer_predict(input t_path_item it, output t_steer_cmd r);
        int          p;
        longint      qx, qy, qz, qw, lv, tv, dx, dy, yn, yd, d, g, lin, turn;
        logic [15:0] yaw, bearing, diff;
        int          mag;
        longint      esg;
        r = '{wpf_pkg::STATUS_NONE, '0, '0, '0, 1'b0};
        if (it.kind == wpf_pkg::KIND_LOAD) begin
            p = load_ptr >= wpf_pkg::MAX_POINTS ? wpf_pkg::MAX_POINTS - 1 : load_ptr;
            if (p == 0) begin
                pt_count = 0; fol_idx = 0; path_done = 1'b0;
            end
            wp_x[p] = it.px;
            wp_y[p] = it.py;
            if (it.last) begin
                pt_count = p + 1; load_ptr = 0;
            end else begin
                load_ptr = p < wpf_pkg::MAX_POINTS - 1 ? p + 1 : p;
            end
            return 1'b0;
        end
        lin = 0; turn = 0;
        if (pt_count == 0) begin
            r.status = wpf_pkg::STATUS_NONE;
        end else if (path_done || fol_idx + 1 >= pt_count) begin
            path_done = 1'b1;
            r.status = wpf_pkg::STATUS_DONE;
        end else begin
            r.status = wpf_pkg::STATUS_CMD;
            qx = it.qx; qy = it.qy; qz = it.qz; qw = it.qw;
            lv = it.lv; tv = it.tv;
            yn = 2 * (qx * qy + qw * qz);
            yd = qw * qw + qx * qx - qy * qy - qz * qz;
            d  = qw * qw + qx * qx + qy * qy + qz * qz;
            g  = 2 * (qx * qz - qw * qy);
            yaw = abs_l(g) >= d ? 16'd0 : vec_angle(yd, yn);
            dx = longint'($signed(wp_x[fol_idx])) - longint'(it.rx);
            dy = longint'($signed(wp_y[fol_idx])) - longint'(it.ry);
            bearing = vec_angle(dx, dy);
            diff = bearing - yaw;
            mag = diff < 16'h8000 ? int'(diff) : 65536 - int'(diff);
            esg = diff == 0 ? 0 : (diff < 16'h8000 ? 1 : -1);
            if (mag >= int'(wide_ang)) begin
                turn = steer_rate(tv, esg);
                if (abs_l(turn) > wpf_pkg::SPIN_MOVE_MIN) lin = lv - longint'(lin_step);
            end else if (mag <= int'(narrow_ang)) begin
                if (abs_l(tv) > wpf_pkg::STRAIGHT_TURN_MIN)
                    turn = tv - sgn_l(tv) * longint'(ang_step);
                if (abs_l(lv) < longint'(v_target)) lin = lv + longint'(lin_step);
                else lin = lv - sgn_l(lv) * longint'(lin_step);
            end else begin
                lin = (lv * tv) >>> 16;
                turn = steer_rate(tv, esg);
            end
            r.lin  = 32'(sat_32(lin));
            r.turn = 32'(sat_32(turn));
            if (abs_l(dx) < (64'sd1 <<< 20) && abs_l(dy) < (64'sd1 <<< 20)) begin
                if (dx * dx + dy * dy < longint'(arrive_r) * longint'(arrive_r)) begin
                    fol_idx++;
                    r.adv = 1'b1;
                end
            end
        end
        r.idx = fol_idx[wpf_pkg::PTR_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d commands outstanding", $time, cmd_queue.size());
            $display("tb_waypoint_heading_follower: done, errors");
            $finish;
        end
    end

    // Result side: random stalls and the check against the oldest expectation.
    always @(negedge i_clk) begin
        if (in_stall > 0) begin
            m_axis_tready <= 1'b0;
            in_stall <= in_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_steer_cmd e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            in_stall <= idle_on ? $urandom_range(0, 3) : 0;
            if (cmd_queue.size() == 0) begin
                $display("%0t unexpected beat: status %0d data %h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = cmd_queue.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $display("%0t status: expected %0d, got %0d", $time, e.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.lin) begin
                    $display("%0t lin_cmd: expected %0d, got %0d", $time, e.lin,
                             $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.turn) begin
                    $display("%0t turn_cmd: expected %0d, got %0d", $time, e.turn,
                             $signed(m_axis_tdata[63:32]));
                    errors++;
                end
                if (m_axis_tdata[73:64] !== e.idx) begin
                    $display("%0t target_index: expected %0d, got %0d", $time, e.idx,
                             m_axis_tdata[73:64]);
                    errors++;
                end
                if (m_axis_tdata[74] !== e.adv) begin
                    $display("%0t advanced: expected %0d, got %0d", $time, e.adv,
                             m_axis_tdata[74]);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input t_path_item it, input bit typed = 1'b0,
                             input t_steer_cmd typed_res = '{wpf_pkg::STATUS_NONE, 0, 0, 0, 0});
        t_steer_cmd r;
        int         gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {it.py, it.px, it.tv, it.lv, it.qw, it.qz, it.qy, it.qx,
                          it.ry, it.rx};
        s_axis_tuser  <= it.kind;
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (steer_predict(it, r)) cmd_queue.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic reg_write(input wpf_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            wpf_pkg::REG_ANG_STEP:     ang_step   = val[16:0];
            wpf_pkg::REG_LIN_STEP:     lin_step   = val[16:0];
            wpf_pkg::REG_V_TARGET:     v_target   = val[18:0];
            wpf_pkg::REG_SPIN_LIMIT:   spin_limit = val[19:0];
            wpf_pkg::REG_ARRIVE:       arrive_r   = val[19:0];
            wpf_pkg::REG_WIDE_ANGLE:   wide_ang   = val[14:0];
            wpf_pkg::REG_NARROW_ANGLE: narrow_ang = val[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Mode 0 writes the low extremes, 1 the high extremes, 2 and up random values.
    task automatic set_gains(input int mode);
        if (mode == 0) begin
            reg_write(wpf_pkg::REG_ANG_STEP, 0);     reg_write(wpf_pkg::REG_LIN_STEP, 0);
            reg_write(wpf_pkg::REG_V_TARGET, 1);     reg_write(wpf_pkg::REG_SPIN_LIMIT, 1);
            reg_write(wpf_pkg::REG_ARRIVE, 0);       reg_write(wpf_pkg::REG_WIDE_ANGLE, 0);
            reg_write(wpf_pkg::REG_NARROW_ANGLE, 0);
        end else if (mode == 1) begin
            reg_write(wpf_pkg::REG_ANG_STEP, 65536);
            reg_write(wpf_pkg::REG_LIN_STEP, 65536);
            reg_write(wpf_pkg::REG_V_TARGET, 327680);
            reg_write(wpf_pkg::REG_SPIN_LIMIT, 655360);
            reg_write(wpf_pkg::REG_ARRIVE, 655360);
            reg_write(wpf_pkg::REG_WIDE_ANGLE, 32767);
            reg_write(wpf_pkg::REG_NARROW_ANGLE, 32767);
        end else begin
            reg_write(wpf_pkg::REG_ANG_STEP, $urandom_range(0, 65536));
            reg_write(wpf_pkg::REG_LIN_STEP, $urandom_range(0, 65536));
            reg_write(wpf_pkg::REG_V_TARGET, $urandom_range(1, 327680));
            reg_write(wpf_pkg::REG_SPIN_LIMIT, $urandom_range(1, 655360));
            reg_write(wpf_pkg::REG_ARRIVE, $urandom_range(1000, 200000));
            reg_write(wpf_pkg::REG_WIDE_ANGLE, $urandom_range(200, 12000));
            reg_write(wpf_pkg::REG_NARROW_ANGLE, $urandom_range(0, 2000));
        end
    endtask

    function automatic t_path_item load_pt(logic [31:0] x, logic [31:0] y, logic last);
        t_path_item it;
        it = '{wpf_pkg::KIND_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, x, y, last};
        return it;
    endfunction

    function automatic t_path_item tick(logic [31:0] rx, logic [31:0] ry, logic [15:0] qx,
                                        logic [15:0] qy, logic [15:0] qz, logic [15:0] qw,
                                        logic [31:0] lv, logic [31:0] tv);
        t_path_item it;
        it = '{wpf_pkg::KIND_TICK, rx, ry, qx, qy, qz, qw, lv, tv, $urandom, $urandom,
               1'($urandom)};
        return it;
    endfunction

    // Tick aimed near the current waypoint, with a mix of orientations and speeds.
    function automatic t_path_item random_tick();
        logic [31:0] rx, ry, lv, tv;
        logic [15:0] qx, qy, qz, qw;
        int          sel;
        rx = wp_x[fol_idx < wpf_pkg::MAX_POINTS ? fol_idx : 0]
             + $signed($urandom_range(0, 'h60000)) - 'h30000;
        ry = wp_y[fol_idx < wpf_pkg::MAX_POINTS ? fol_idx : 0]
             + $signed($urandom_range(0, 'h60000)) - 'h30000;
        if ($urandom_range(0, 9) == 0) begin
            rx = $urandom; ry = $urandom;
        end
        sel = $urandom_range(0, 9);
        qx = $urandom; qy = $urandom; qz = $urandom; qw = $urandom;
        if (sel < 6) begin
            qx = 0; qy = 0;
        end else if (sel == 6) begin
            qx = 0; qy = 0; qz = 0; qw = 0;
        end
        lv = $signed($urandom_range(0, 'h60000)) - 'h30000;
        tv = $signed($urandom_range(0, 'h60000)) - 'h30000;
        if ($urandom_range(0, 7) == 0) lv = $urandom;
        if ($urandom_range(0, 7) == 0) tv = $urandom;
        if ($urandom_range(0, 5) == 0) tv = $signed($urandom_range(0, 4000)) - 2000;
        return tick(rx, ry, qx, qy, qz, qw, lv, tv);
    endfunction

    t_stim_row directed[$];

    initial begin
        int          n_sent;
        int          len;
        logic [31:0] bx, by;
        ang_step = 655; lin_step = 655; v_target = 32768; spin_limit = 131072;
        arrive_r = 6554; wide_ang = 1820; narrow_ang = 273;
        load_ptr = 0; pt_count = 0; fol_idx = 0; path_done = 1'b0;
        foreach (wp_x[i]) begin
            wp_x[i] = '0; wp_y[i] = '0;
        end

        // Directed part, with reset defaults in force.
        directed = '{
            '{tick(0, 0, 0, 0, 0, 32767, 0, 0), 1'b1,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{load_pt(0, 0, 1'b0), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{load_pt(32'h0010_0000, 0, 1'b1), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 0, 0, 0, 32767, 100, 100), 1'b1,
              '{wpf_pkg::STATUS_DONE, 0, 0, 1, 1'b0}},
            '{tick(0, 0, 0, 0, 0, 32767, 100, 100), 1'b1,
              '{wpf_pkg::STATUS_DONE, 0, 0, 1, 1'b0}},
            '{load_pt(32'h03E8_0000, 0, 1'b0), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{load_pt(32'hFC18_0000, 32'h01F4_0000, 1'b0), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{load_pt(32'h7FFF_FFFF, 32'h8000_0000, 1'b0), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{load_pt(0, 0, 1'b1), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            // Straight ahead, accelerating from rest.
            '{tick(0, 0, 0, 0, 0, 32767, 0, 0), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 0, 0, 0, 32767, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            // Waypoint exactly behind: a half-turn error.
            '{tick(32'h07D0_0000, 0, 0, 0, 0, 32767, 1000, 2000), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            // Facing sideways, and a turn-mode heading of about ten degrees.
            '{tick(0, 0, 0, 0, 23170, 23170, 32'h0002_0000, 32'hFFFF_0000), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 0, 0, 2856, 32643, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0001_0000,
                   32'h0001_0000), 1'b0, '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(0, 0, 16'h7FFF, 0, 16'h7FFF, 0, 500, 600), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            // Arrive at the first point, then tick from the far corner.
            '{tick(32'h03E8_0000, 16, 0, 0, 0, 32767, 0, 0), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}},
            '{tick(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32767, 0, 0), 1'b0,
              '{wpf_pkg::STATUS_NONE, 0, 0, 0, 1'b0}}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].res);
        drain_outputs();

        // An over-long path piles the tail onto the final entry; all points
        // sit at the origin so every tick advances.
        reg_write(wpf_pkg::REG_ARRIVE, 65536);
        for (int i = 0; i < wpf_pkg::MAX_POINTS + 6; i++) begin
            send_item(load_pt(0, 0, i == wpf_pkg::MAX_POINTS + 5));
        end
        idle_on = 1'b0;
        for (int i = 0; i < 10; i++) begin
            send_item(tick(0, 0, 0, 0, 0, 32767, $urandom, $urandom));
        end
        idle_on = 1'b1;
        drain_outputs();

        // Random paths in phases separated by register changes.
        n_sent = 0;
        for (int ph = 0; n_sent < 600; ph++) begin
            set_gains(ph);
            idle_on = (ph % 3) != 2;
            for (int k = 0; k < 12; k++) begin
                len = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
                bx = $urandom_range(0, 7) == 0 ? $urandom
                     : $signed($urandom_range(0, 'h100000)) - 'h80000;
                by = $signed($urandom_range(0, 'h100000)) - 'h80000;
                for (int j = 0; j < len; j++) begin
                    send_item(load_pt(bx + $signed($urandom_range(0, 'h80000)) - 'h40000,
                                      by + $signed($urandom_range(0, 'h80000)) - 'h40000,
                                      j == len - 1 && $urandom_range(0, 15) != 0));
                end
                for (int j = $urandom_range(3, 12); j > 0; j--) begin
                    send_item(random_tick());
                    n_sent++;
                end
            end
            drain_outputs();
        end

        if (errors == 0)
            $display("tb_waypoint_heading_follower: done, clean");
        else
            $display("tb_waypoint_heading_follower: done, errors");
        $finish;
    end

endmodule
